// ----- sv/eipt_pkg.sv -----
// Package: shared types and constants for the encoder index position tracker.
`timescale 1ns / 1ps
`default_nettype none

package eipt_pkg;

    localparam int unsigned CountWidth = 32;
    localparam int unsigned HalfWidth  = 16;
    localparam int unsigned PosWidth   = 64;

    // Tracker state carried from one sample to the next
    typedef struct packed {
        logic [CountWidth-1:0]      previous_count;
        logic                       previous_index;
        logic signed [PosWidth-1:0] position_accum;
        logic [CountWidth-1:0]      index_counter;
        logic [CountWidth-1:0]      latched_index_count;
    } eipt_state_t;

    // One sample as taken from the input channel
    typedef struct packed {
        logic [CountWidth-1:0] counter_value;
        logic                  index_level;
    } eipt_sample_t;

    // One result as presented on the output channel
    typedef struct packed {
        logic signed [CountWidth-1:0] step_delta;
        logic signed [PosWidth-1:0]   position_total;
        logic [CountWidth-1:0]        count_now;
        logic [CountWidth-1:0]        index_events;
        logic [CountWidth-1:0]        count_at_index;
        logic                         index_level_now;
        logic                         clear_counter;
    } eipt_result_t;

endpackage

`default_nettype wire

// ----- sv/eipt_calc.sv -----
// Module: per-sample delta, accumulation and index-edge logic.
`timescale 1ns / 1ps
`default_nettype none

module eipt_calc
    import eipt_pkg::*;
(
    input  wire logic         counter_is_16bit,
    input  wire eipt_sample_t sample,
    input  wire eipt_state_t  state_cur,
    output eipt_state_t       state_next,
    output eipt_result_t      result
);

    logic [CountWidth-1:0]        count_masked;
    logic [CountWidth-1:0]        diff;
    logic signed [CountWidth-1:0] delta;
    logic signed [PosWidth-1:0]   accum_sum;
    logic                         index_rise;

    // Mask the count, form the modular delta and accumulate
    always_comb
    begin
        if (counter_is_16bit)
        begin
            count_masked = {{(CountWidth-HalfWidth){1'b0}},
                            sample.counter_value[HalfWidth-1:0]};
        end
        else
        begin
            count_masked = sample.counter_value;
        end

        diff = count_masked - state_cur.previous_count;

        if (counter_is_16bit)
        begin
            delta = {{(CountWidth-HalfWidth){diff[HalfWidth-1]}}, diff[HalfWidth-1:0]};
        end
        else
        begin
            delta = diff;
        end

        accum_sum  = state_cur.position_accum
                   + {{(PosWidth-CountWidth){delta[CountWidth-1]}}, delta};
        index_rise = sample.index_level & ~state_cur.previous_index;
    end

    // Update state; on an index rising edge latch the count and zero the previous count
    always_comb
    begin
        state_next.position_accum = accum_sum;
        if (index_rise)
        begin
            state_next.previous_count      = '0;
            state_next.previous_index      = 1'b1;
            state_next.index_counter       = state_cur.index_counter
                                           + {{(CountWidth-1){1'b0}}, 1'b1};
            state_next.latched_index_count = count_masked;
        end
        else
        begin
            state_next.previous_count      = count_masked;
            state_next.previous_index      = sample.index_level;
            state_next.index_counter       = state_cur.index_counter;
            state_next.latched_index_count = state_cur.latched_index_count;
        end

        result.step_delta      = delta;
        result.position_total  = accum_sum;
        result.count_now       = index_rise ? '0 : count_masked;
        result.index_events    = state_next.index_counter;
        result.count_at_index  = state_next.latched_index_count;
        result.index_level_now = sample.index_level;
        result.clear_counter   = index_rise;
    end

endmodule

`default_nettype wire

// ----- sv/encoder_index_position_tracker.sv -----
// Module: top level of the quadrature encoder position tracker with index handling.
//
//  channel   direction  handshake              payload
//  -------   ---------  ---------------------  ------------------------------------------
//  cfg       in         cfg_we                 cfg_wdata (counter_is_16bit)
//  in        in         in_valid / in_ready    counter_value, index_level
//  out       out        out_valid / out_ready  step_delta, position_total, count_now,
//                                              index_events, count_at_index,
//                                              index_level_now, clear_counter
//
//  One sample per cycle sustained while the output is not stalled; an accepted sample
//  enters the input register and is then loaded into the result register when that
//  register is free or draining (one pass of subtract/add between the two).
//  The 64-bit position add sets the critical path.
//  rst_n clears the mode register, all tracker state and both valid flags.
//  A stalled output holds its result; the input register still takes a sample
//  while the result register drains in the same cycle.
`timescale 1ns / 1ps
`default_nettype none

module encoder_index_position_tracker
    import eipt_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic                         cfg_wdata,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [CountWidth-1:0]        counter_value,
    input  wire logic                         index_level,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic signed [CountWidth-1:0]      step_delta,
    output logic signed [PosWidth-1:0]        position_total,
    output logic [CountWidth-1:0]             count_now,
    output logic [CountWidth-1:0]             index_events,
    output logic [CountWidth-1:0]             count_at_index,
    output logic                              index_level_now,
    output logic                              clear_counter
);

    logic         mode16_reg;
    logic         s1_valid_reg;
    eipt_sample_t s1_sample_reg;
    eipt_state_t  state_reg;
    eipt_state_t  state_next;
    logic         out_valid_reg;
    eipt_result_t result_reg;
    eipt_result_t result_next;
    logic         advance;
    logic         in_fire;

    // Move a sample to the result register when that register is free or draining
    assign advance  = s1_valid_reg & (~out_valid_reg | out_ready);
    assign in_ready = ~s1_valid_reg | advance;
    assign in_fire  = in_valid & in_ready;

    // Hold the counter width mode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode16_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            mode16_reg <= cfg_wdata;
        end
    end

    // Capture an incoming transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_sample_reg <= '{counter_value: counter_value, index_level: index_level};
        end
    end

    eipt_calc u_calc (
        .counter_is_16bit (mode16_reg),
        .sample           (s1_sample_reg),
        .state_cur        (state_reg),
        .state_next       (state_next),
        .result           (result_next)
    );

    // Advance tracker state once per processed sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Hold the result until the output transaction completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    // Drive the output channel
    assign out_valid       = out_valid_reg;
    assign step_delta      = result_reg.step_delta;
    assign position_total  = result_reg.position_total;
    assign count_now       = result_reg.count_now;
    assign index_events    = result_reg.index_events;
    assign count_at_index  = result_reg.count_at_index;
    assign index_level_now = result_reg.index_level_now;
    assign clear_counter   = result_reg.clear_counter;

endmodule

`default_nettype wire

// ----- sim/tb_encoder_index_position_tracker.sv -----
// Testbench: self-checking run of the encoder index position tracker against a local predictor.
`timescale 1ns / 1ps

module tb_encoder_index_position_tracker;
    import eipt_pkg::*;

    localparam int unsigned StallLimit = 1000;

    logic                         clk           = 1'b0;
    logic                         rst_n         = 1'b0;
    logic                         cfg_we        = 1'b0;
    logic                         cfg_wdata     = 1'b0;
    logic                         in_valid      = 1'b0;
    logic                         in_ready;
    logic [CountWidth-1:0]        counter_value = '0;
    logic                         index_level   = 1'b0;
    logic                         out_valid;
    logic                         out_ready     = 1'b0;
    logic signed [CountWidth-1:0] step_delta;
    logic signed [PosWidth-1:0]   position_total;
    logic [CountWidth-1:0]        count_now;
    logic [CountWidth-1:0]        index_events;
    logic [CountWidth-1:0]        count_at_index;
    logic                         index_level_now;
    logic                         clear_counter;

    // Tracker copy kept by the testbench
    logic                         trk_mode16       = 1'b0;
    logic [CountWidth-1:0]        trk_prev_count   = '0;
    logic                         trk_prev_z       = 1'b0;
    logic [PosWidth-1:0]          trk_position     = '0;
    logic [CountWidth-1:0]        trk_index_events = '0;
    logic [CountWidth-1:0]        trk_index_latch  = '0;

    eipt_result_t                 pending_results[$];
    int unsigned                  mismatches   = 0;
    int unsigned                  quiet_cycles = 0;
    int unsigned                  tx_idle_odds = 0;
    int unsigned                  rx_idle_odds = 0;

    // Encoder-like stimulus state
    logic [CountWidth-1:0]        walk_count = '0;
    int unsigned                  z_left     = 0;
    logic [CountWidth-1:0]        corner_counts [8] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
        32'h0000_FFFF, 32'h0000_8000, 32'h0000_7FFF, 32'h0001_0000
    };

    encoder_index_position_tracker DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .counter_value   (counter_value),
        .index_level     (index_level),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .step_delta      (step_delta),
        .position_total  (position_total),
        .count_now       (count_now),
        .index_events    (index_events),
        .count_at_index  (count_at_index),
        .index_level_now (index_level_now),
        .clear_counter   (clear_counter)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Advance the tracker copy by one sample and return the result it should produce
    function automatic eipt_result_t track_sample(input logic [CountWidth-1:0] raw,
                                                  input logic z);
        eipt_result_t          res;
        logic [CountWidth-1:0] masked;
        logic [CountWidth-1:0] diff;
        logic [CountWidth-1:0] delta;
        masked = raw & (trk_mode16 ? 32'h0000_FFFF : 32'hFFFF_FFFF);
        diff   = masked - trk_prev_count;
        delta  = trk_mode16 ? {{16{diff[15]}}, diff[15:0]} : diff;
        trk_position = trk_position + {{32{delta[31]}}, delta};
        res.clear_counter = 1'b0;
        res.count_now     = masked;
        if (z && !trk_prev_z)
        begin
            // Rising index edge: latch and request a counter clear
            trk_index_latch   = masked;
            trk_index_events  = trk_index_events + 1;
            trk_prev_count    = '0;
            trk_prev_z        = 1'b1;
            res.count_now     = '0;
            res.clear_counter = 1'b1;
        end
        else
        begin
            trk_prev_count = masked;
            trk_prev_z     = z;
        end
        res.step_delta      = delta;
        res.position_total  = trk_position;
        res.index_events    = trk_index_events;
        res.count_at_index  = trk_index_latch;
        res.index_level_now = z;
        return res;
    endfunction

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        end
    endtask

    // Check each result transaction, then predict from each accepted sample
    always @(posedge clk)
    begin
        eipt_result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, actual delta %h pos %h",
                             $time, step_delta, position_total);
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("step_delta", want.step_delta, step_delta);
                    check_field("position_total", want.position_total, position_total);
                    check_field("count_now", want.count_now, count_now);
                    check_field("index_events", want.index_events, index_events);
                    check_field("count_at_index", want.count_at_index, count_at_index);
                    check_field("index_level_now", want.index_level_now, index_level_now);
                    check_field("clear_counter", want.clear_counter, clear_counter);
                end
            end
            if (in_valid && in_ready)
                pending_results.push_back(track_sample(counter_value, index_level));
        end
    end

    // Stop the run when no transaction moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= StallLimit)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Stall the result side in random bursts
    always
    begin
        @(posedge clk);
        if (rx_idle_odds != 0 && $urandom_range(1, rx_idle_odds) == 1)
        begin
            out_ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        out_ready <= 1'b1;
    end

    // Present one sample and hold it until the tracker takes it
    task automatic send_sample(input logic [CountWidth-1:0] value, input logic z);
        in_valid      <= 1'b1;
        counter_value <= value;
        index_level   <= z;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (tx_idle_odds != 0 && $urandom_range(1, tx_idle_odds) == 1)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    endtask

    // Drop valid and wait until every accepted sample has come out
    task automatic drain_results;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Drain, then write the counter width register
    task automatic write_counter_mode(input logic mode16);
        drain_results();
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= mode16;
        @(posedge clk);
        cfg_we     <= 1'b0;
        trk_mode16 = mode16;
    endtask

    // Build one sample: mostly a random walk with index pulses, some noise and corners
    task automatic next_encoder_sample(output logic [CountWidth-1:0] value, output logic z);
        int unsigned kind;
        kind = $urandom_range(0, 99);
        if (kind < 70)
            walk_count = walk_count + $urandom_range(0, 400) - 200;
        else if (kind < 85)
            walk_count = $urandom();
        else
            walk_count = corner_counts[$urandom_range(0, 7)];
        value = walk_count;
        if ($urandom_range(0, 9) == 0)
            value[31:16] = $urandom_range(0, 65535);
        if (z_left != 0)
        begin
            z = 1'b1;
            z_left--;
        end
        else if ($urandom_range(0, 19) == 0)
        begin
            // Start an index pulse; the external counter restarts near zero
            z          = 1'b1;
            z_left     = $urandom_range(0, 4);
            walk_count = $urandom_range(0, 20);
        end
        else
            z = 1'b0;
    endtask

    task automatic test_count_extremes_32bit;
        send_sample(32'h0000_0000, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b0);
        send_sample(32'h0000_0000, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h0000_0000, 1'b0);
        send_sample(32'h1234_5678, 1'b1);
        send_sample(32'h0000_0005, 1'b1);
        send_sample(32'hAAAA_AAAA, 1'b0);
        send_sample(32'h5555_5555, 1'b1);
        send_sample(32'hFFFF_FFFF, 1'b0);
    endtask

    task automatic test_count_extremes_16bit;
        // Previous count still holds 32 bits across the mode change
        write_counter_mode(1'b1);
        send_sample(32'hABCD_1234, 1'b0);
        send_sample(32'h0000_FFFF, 1'b0);
        send_sample(32'h0001_0000, 1'b0);
        send_sample(32'h0000_8000, 1'b0);
        send_sample(32'hFFFF_7FFF, 1'b1);
        send_sample(32'h0000_0000, 1'b0);
        send_sample(32'h0000_FFFF, 1'b1);
        send_sample(32'h5555_AAAA, 1'b1);
        write_counter_mode(1'b0);
        send_sample(32'hDEAD_BEEF, 1'b0);
    endtask

    task automatic run_traffic(input int unsigned items, input logic mode16);
        logic [CountWidth-1:0] value;
        logic                  z;
        write_counter_mode(mode16);
        repeat (items)
        begin
            next_encoder_sample(value, z);
            send_sample(value, z);
        end
    endtask

    task automatic test_encoder_traffic;
        int unsigned odds_choice [3] = '{0, 3, 10};
        for (int chunk = 0; chunk < 16; chunk++)
        begin
            tx_idle_odds = odds_choice[$urandom_range(0, 2)];
            rx_idle_odds = odds_choice[$urandom_range(0, 2)];
            run_traffic(50, (chunk < 2) ? chunk[0] : 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic test_back_to_back_traffic;
        tx_idle_odds = 0;
        rx_idle_odds = 0;
        run_traffic(110, 1'b1);
        run_traffic(110, 1'b0);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        tx_idle_odds = 4;
        rx_idle_odds = 4;
        test_count_extremes_32bit();
        test_count_extremes_16bit();
        test_encoder_traffic();
        test_back_to_back_traffic();
        drain_results();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
